// File: rtl/core/plt_pkg.sv
// Shared command, status codes and cell control type for the positional list table.
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_CONSULT = 2'd2;
    localparam logic [1:0] CMD_SEARCH  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // Operation broadcast to every cell of the row on the accept cycle.
    typedef struct packed {
        logic ins;   // shift toward the tail from the target index, load at target
        logic rem;   // shift toward the head from the target index
        logic rd;    // capture the entry at the target index
        logic srch;  // compare the stored entry with the broadcast value
    } t_cell_op;

endpackage

`default_nettype wire

// File: rtl/core/plt_cell.sv
// One storage cell of the list row: holds a single entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module plt_cell #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 16,
    parameter int IDX        = 0
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire plt_pkg::t_cell_op             i_op,
    input  wire [$clog2(CAPACITY)-1:0]         i_idx,
    input  wire [$clog2(CAPACITY+1)-1:0]       i_count,
    input  wire [VALUE_BITS-1:0]               i_value,
    input  wire [VALUE_BITS-1:0]               i_left,
    input  wire [VALUE_BITS-1:0]               i_right,
    output logic [VALUE_BITS-1:0]              o_entry,
    output logic [VALUE_BITS-1:0]              o_sel,
    output logic                               o_match
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    logic [VALUE_BITS-1:0] r_entry;
    logic [VALUE_BITS-1:0] r_sel;
    logic                  r_match;

    always_ff @(posedge i_clk) begin
        if (i_op.ins) begin
            if (MY_IDX > i_idx) begin
                r_entry <= i_left;
            end else if (MY_IDX == i_idx) begin
                r_entry <= i_value;
            end
        end else if (i_op.rem && (MY_IDX >= i_idx)) begin
            r_entry <= i_right;
        end
    end

    // The read capture and the search flag see the contents from before the shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= '0;
            r_match <= 1'b0;
        end else begin
            r_sel   <= (i_op.rd && (MY_IDX == i_idx)) ? r_entry : '0;
            r_match <= i_op.srch && (MY_POS < i_count) && (r_entry == i_value);
        end
    end

    assign o_entry = r_entry;
    assign o_sel   = r_sel;
    assign o_match = r_match;

endmodule

`default_nettype wire

// File: rtl/core/positional_list_table.sv
// Top level of the positional list table: command decode, cell row and result reduction.
`timescale 1ns / 1ps
`default_nettype none

// Bounded ordered list of handles held in a row of cells, one entry per cell.
// A command beat is taken at a clock edge where start is high and busy is low.
// Commands: insert at a position (or append), remove or consult by position
// (or the last entry), and search for the first entry equal to a value.
// On the accept edge every cell shifts, loads or captures in parallel, so an
// insert or remove moves the whole tail of the list at that edge. In the next
// cycle the captured values and match flags of all cells are reduced and the
// result is registered.
// The result beat is registered at the edge that ends the busy cycle, and it
// shows on the o_ ports, with o_done high, for one cycle. busy is high for the
// one cycle between the accept edge and the result beat, so no command is taken
// while a result is being formed; a new one can be taken while the result shows.
// Every result reports the entry count after the command.
// Reset empties the list; the cells themselves are not cleared, since only
// entries below the count are ever read.
// The receiver cannot stall: each result beat is taken in its single cycle.
module positional_list_table #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_command,
    input  wire  [15:0] i_item_value,
    input  wire  [4:0]  i_position,
    input  wire         i_at_end,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_value_out,
    output logic [3:0]  o_found_index,
    output logic [4:0]  o_count
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_busy;
    logic                  r_done;
    logic [1:0]            r_cmd;
    logic                  r_rej;
    logic [1:0]            r_status;
    logic [15:0]           r_value_out;
    logic [3:0]            r_found_index;

    logic                  accept;
    logic [VALUE_BITS-1:0] value;
    logic [CMPW-1:0]       pos_x;
    logic [CMPW-1:0]       cnt_x;
    logic                  is_ins;
    logic                  is_rdcmd;
    logic                  ins_ok;
    logic                  rd_ok;
    logic [IW-1:0]         tgt_idx;
    plt_pkg::t_cell_op     op;

    logic [VALUE_BITS-1:0] entry [CAPACITY];
    logic [VALUE_BITS-1:0] sel   [CAPACITY];
    logic [CAPACITY-1:0]   match;
    logic [VALUE_BITS-1:0] sel_or;
    logic [IW-1:0]         first_idx;
    logic                  any_match;

    assign accept   = start && !r_busy;
    assign value    = VALUE_BITS'(i_item_value);
    assign pos_x    = CMPW'(i_position);
    assign cnt_x    = CMPW'(r_count);
    assign is_ins   = (i_command == plt_pkg::CMD_INSERT);
    assign is_rdcmd = (i_command == plt_pkg::CMD_REMOVE)
                   || (i_command == plt_pkg::CMD_CONSULT);
    assign ins_ok   = is_ins && (r_count < CW'(CAPACITY));
    assign rd_ok    = is_rdcmd && (r_count != '0) && (i_at_end || (pos_x < cnt_x));

    always_comb begin
        if (is_ins) begin
            // Append when asked, or when the position lies at or past the tail.
            tgt_idx = (i_at_end || (pos_x >= cnt_x)) ? IW'(r_count) : IW'(i_position);
        end else begin
            tgt_idx = i_at_end ? IW'(r_count - CW'(1)) : IW'(i_position);
        end
    end

    always_comb begin
        op.ins  = accept && ins_ok;
        op.rem  = accept && rd_ok && (i_command == plt_pkg::CMD_REMOVE);
        op.rd   = accept && rd_ok;
        op.srch = accept && (i_command == plt_pkg::CMD_SEARCH);
    end

    always_comb begin
        n_count = r_count;
        if (op.ins) begin
            n_count = r_count + CW'(1);
        end else if (op.rem) begin
            n_count = r_count - CW'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [VALUE_BITS-1:0] left_v;
            logic [VALUE_BITS-1:0] right_v;
            if (g == 0) begin : g_head
                assign left_v = '0;
            end else begin : g_mid_l
                assign left_v = entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign right_v = '0;
            end else begin : g_mid_r
                assign right_v = entry[g+1];
            end
            plt_cell #(
                .CAPACITY   (CAPACITY),
                .VALUE_BITS (VALUE_BITS),
                .IDX        (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_op    (op),
                .i_idx   (tgt_idx),
                .i_count (r_count),
                .i_value (value),
                .i_left  (left_v),
                .i_right (right_v),
                .o_entry (entry[g]),
                .o_sel   (sel[g]),
                .o_match (match[g])
            );
        end
    endgenerate

    // Only the target cell captures a nonzero value, so an OR picks it out.
    always_comb begin
        sel_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_or = sel_or | sel[i];
        end
    end

    always_comb begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match[i]) begin
                first_idx = IW'(i);
            end
        end
    end

    assign any_match = |match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= accept;
            r_done  <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_rej <= !(ins_ok || rd_ok);
        end
        if (r_busy) begin
            if (r_cmd == plt_pkg::CMD_SEARCH) begin
                r_status      <= any_match ? plt_pkg::ST_OK : plt_pkg::ST_NOTFOUND;
                r_found_index <= 4'(first_idx);
            end else begin
                r_status      <= r_rej ? plt_pkg::ST_REJECT : plt_pkg::ST_OK;
                r_found_index <= '0;
            end
            r_value_out <= 16'(sel_or);
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_value_out   = r_value_out;
    assign o_found_index = r_found_index;
    assign o_count       = 5'(r_count);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("result beat did not follow the busy cycle");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == plt_pkg::ST_REJECT)) |-> (o_value_out == '0))
        else $error("rejected command returned a value");

    a_notfound_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == plt_pkg::ST_NOTFOUND)) |-> (o_found_index == '0))
        else $error("failed search returned a nonzero index");

endmodule

`default_nettype wire
